// ===== design/cnv3_pkg.sv =====
// Shared types and constants of the 3x3 RGB convolution block.
// No dependencies; every other file of the block depends on it.
package cnv3_pkg;

	localparam int CH_W = 8;
	localparam int PIX_W = 3 * CH_W;
	localparam int COEF_W = 16;
	localparam int FRAC_W = 12;
	localparam int PROD_W = COEF_W + CH_W + 1;
	localparam int ROW_W = PROD_W + 2;
	localparam int ACC_W = PROD_W + 3;
	localparam int ROW_OUT_W = 12;
	localparam int COL_OUT_W = 10;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 48;
	localparam int FRAME_WIDTH_RST = 640;
	localparam int FRAME_HEIGHT_RST = 480;
	localparam logic [CFG_DATA_W-1:0] KERN_TOP_RST = 48'h0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] KERN_MID_RST = 48'h0000_1000_0000;
	localparam logic [CFG_DATA_W-1:0] KERN_BOT_RST = 48'h0000_0000_0000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KERNEL_TOP    = 3'd0,
		REG_KERNEL_MID    = 3'd1,
		REG_KERNEL_BOTTOM = 3'd2,
		REG_FRAME_WIDTH   = 3'd3,
		REG_FRAME_HEIGHT  = 3'd4
	} cfg_reg_t;

	// {blue, green, red}
	typedef logic [PIX_W-1:0] rgb_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	// [kernel row][kernel column]
	typedef coef_t [2:0][2:0] kernel_t;
	typedef rgb_t [2:0][2:0] taps_t;

	typedef struct packed {
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] col;
		logic                 last;
	} pos_t;

	typedef struct packed {
		rgb_t                 pix;
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] col;
		logic                 emit;
		logic                 last_row;
		logic                 row_end;
		logic                 row_one;
		logic                 col_one;
	} item_t;

	typedef struct packed {
		taps_t taps;
		pos_t  pos;
	} issue_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		pos_t            pos;
	} result_t;

endpackage

// ===== design/cnv3_if.sv =====
// Stream and configuration channel interfaces of the 3x3 convolution block.
// Depends on cnv3_pkg for the configuration field widths.
interface cnv3_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	modport source (output valid, output in_red, output in_green, output in_blue, input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

interface cnv3_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic [11:0] out_row;
	logic [9:0]  out_col;
	logic        last_in_run;
	modport source (output valid, output out_red, output out_green, output out_blue,
		output out_row, output out_col, output last_in_run, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input out_row, input out_col, input last_in_run, output ready);
endinterface

interface cnv3_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [cnv3_pkg::CFG_INDEX_W-1:0] index;
	logic [cnv3_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/cnv3_line_store.sv =====
// Raster position tracking and the two line stores, kept as one 48-bit wide
// synchronous memory (older row, newer row). Depends on cnv3_pkg.
module cnv3_line_store #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  cnv3_pkg::rgb_t                pix,
	input  logic [$clog2(MAX_WIDTH)-1:0]  wlast,
	input  logic [$clog2(MAX_HEIGHT)-1:0] hlast,
	input  logic                          advance,
	output logic                          s1_valid,
	output cnv3_pkg::item_t               s1_item,
	output cnv3_pkg::rgb_t                top_px,
	output cnv3_pkg::rgb_t                mid_px
);
	import cnv3_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CW-1:0]           col_q, col_cur, col_nxt, addr_s1;
	logic [RW-1:0]           row_q, row_cur, row_nxt;
	logic                    last_row, row_end;
	logic [RW+ROW_OUT_W-1:0] row_ext;
	logic [CW+COL_OUT_W-1:0] col_ext;
	logic [2*PIX_W-1:0]      mem [MAX_WIDTH];
	logic [2*PIX_W-1:0]      rd_q;
	item_t                   item_s1;
	logic                    valid_s1;

	always_comb begin
		col_cur = (col_q > wlast) ? wlast : col_q;
		row_cur = (row_q > hlast) ? hlast : row_q;
		last_row = (row_cur == hlast);
		row_end = (col_cur == wlast);
		if (row_end) begin
			col_nxt = '0;
			row_nxt = last_row ? '0 : row_cur + RW'(1);
		end else begin
			col_nxt = col_cur + CW'(1);
			row_nxt = row_cur;
		end
		row_ext = {{ROW_OUT_W{1'b0}}, row_cur};
		col_ext = {{COL_OUT_W{1'b0}}, col_cur};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			col_q <= '0;
			row_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				col_q <= col_nxt;
				row_q <= row_nxt;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= col_cur;
			item_s1.pix <= pix;
			item_s1.row <= row_ext[ROW_OUT_W-1:0];
			item_s1.col <= col_ext[COL_OUT_W-1:0];
			item_s1.emit <= (row_cur != '0) && (col_cur != '0);
			item_s1.last_row <= last_row;
			item_s1.row_end <= row_end;
			item_s1.row_one <= (row_cur == RW'(1));
			item_s1.col_one <= (col_cur == CW'(1));
		end
	end

	// read at acceptance, write back the shifted pair when the item leaves
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem[col_cur];
		end
		if (advance) begin
			mem[addr_s1] <= {rd_q[PIX_W-1:0], item_s1.pix};
		end
	end

	assign s1_valid = valid_s1;
	assign s1_item = item_s1;
	assign top_px = rd_q[2*PIX_W-1:PIX_W];
	assign mid_px = rd_q[PIX_W-1:0];

endmodule

// ===== design/cnv3_window_seq.sv =====
// 3x3 pixel window and the result sequencer that issues one border variant of
// the current window per cycle while en is high. Depends on cnv3_pkg.
module cnv3_window_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             s1_valid,
	input  cnv3_pkg::item_t  s1_item,
	input  cnv3_pkg::rgb_t   top_px,
	input  cnv3_pkg::rgb_t   mid_px,
	output logic             take,
	output logic             issue_valid,
	output cnv3_pkg::issue_t issue
);
	import cnv3_pkg::*;

	// [window column][window row], row 0 on top
	rgb_t [2:0][2:0] win_q;
	rgb_t [2:0]      colv;
	logic            valid_s2;
	item_t           item_s2;
	logic [1:0]      var_q, var_nxt;
	logic            more, final_res;
	logic [1:0]      rsel [3];
	logic [1:0]      csel [3];

	always_comb begin
		if (!var_q[0] && item_s2.last_row) begin
			more = 1'b1;
			var_nxt = {var_q[1], 1'b1};
		end else if (!var_q[1] && item_s2.row_end) begin
			more = 1'b1;
			var_nxt = 2'b10;
		end else begin
			more = 1'b0;
			var_nxt = var_q;
		end
		final_res = !item_s2.emit || !more;
		take = en && (!valid_s2 || final_res);
		issue_valid = valid_s2 && item_s2.emit;
	end

	always_comb begin
		rsel[0] = var_q[0] ? 2'd1 : (item_s2.row_one ? 2'd2 : 2'd0);
		rsel[1] = var_q[0] ? 2'd2 : 2'd1;
		rsel[2] = 2'd2;
		csel[0] = var_q[1] ? 2'd1 : (item_s2.col_one ? 2'd2 : 2'd0);
		csel[1] = var_q[1] ? 2'd2 : 2'd1;
		csel[2] = 2'd2;
		colv = win_q[0];
		issue.taps = '0;
		for (int j = 0; j < 3; j++) begin
			case (csel[j])
				2'd0: colv = win_q[0];
				2'd1: colv = win_q[1];
				default: colv = win_q[2];
			endcase
			for (int i = 0; i < 3; i++) begin
				case (rsel[i])
					2'd0: issue.taps[i][j] = colv[0];
					2'd1: issue.taps[i][j] = colv[1];
					default: issue.taps[i][j] = colv[2];
				endcase
			end
		end
		issue.pos.row = var_q[0] ? item_s2.row : item_s2.row - ROW_OUT_W'(1);
		issue.pos.col = var_q[1] ? item_s2.col : item_s2.col - COL_OUT_W'(1);
		issue.pos.last = final_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			var_q <= '0;
			win_q <= '0;
		end else begin
			if (take) begin
				valid_s2 <= s1_valid;
				var_q <= '0;
				if (s1_valid) begin
					win_q[0] <= win_q[1];
					win_q[1] <= win_q[2];
					win_q[2][0] <= top_px;
					win_q[2][1] <= mid_px;
					win_q[2][2] <= s1_item.pix;
				end
			end else if (en && valid_s2) begin
				var_q <= var_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && s1_valid) begin
			item_s2 <= s1_item;
		end
	end

endmodule

// ===== design/cnv3_filter.sv =====
// Multiply, row-sum and final-sum pipeline with floor and clamp to 0..255,
// ending in the output register. Depends on cnv3_pkg.
module cnv3_filter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              out_ready,
	input  logic              issue_valid,
	input  cnv3_pkg::issue_t  issue,
	input  cnv3_pkg::kernel_t kernel,
	output logic              en,
	output logic              out_valid,
	output cnv3_pkg::result_t result
);
	import cnv3_pkg::*;

	logic signed [PROD_W-1:0] prod_s3 [3][3][3];
	logic signed [ROW_W-1:0]  rsum_s4 [3][3];
	logic signed [ACC_W-1:0]  acc [3];
	pos_t                     pos_s3, pos_s4;
	logic                     valid_s3, valid_s4, valid_q;
	result_t                  result_q;

	function automatic logic [CH_W-1:0] clamp_pix(input logic signed [ACC_W-1:0] sum);
		logic [CH_W-1:0] q;
		if (sum[ACC_W-1] || sum == '0) begin
			q = '0;
		end else if (|sum[ACC_W-2:FRAC_W+CH_W]) begin
			q = '1;
		end else begin
			q = sum[FRAC_W+CH_W-1:FRAC_W];
		end
		return q;
	endfunction

	assign en = !valid_q || out_ready;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			acc[ch] = ACC_W'(rsum_s4[ch][0]) + ACC_W'(rsum_s4[ch][1]) + ACC_W'(rsum_s4[ch][2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			valid_s3 <= issue_valid;
			valid_s4 <= valid_s3;
			valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++) begin
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						prod_s3[ch][i][j] <= $signed(kernel[i][j]) *
							$signed({1'b0, issue.taps[i][j][CH_W*ch +: CH_W]});
					end
					rsum_s4[ch][i] <= ROW_W'(prod_s3[ch][i][0]) + ROW_W'(prod_s3[ch][i][1]) +
						ROW_W'(prod_s3[ch][i][2]);
				end
			end
			pos_s3 <= issue.pos;
			pos_s4 <= pos_s3;
			result_q.red <= clamp_pix(acc[0]);
			result_q.green <= clamp_pix(acc[1]);
			result_q.blue <= clamp_pix(acc[2]);
			result_q.pos <= pos_s4;
		end
	end

	assign out_valid = valid_q;
	assign result = result_q;

endmodule

// ===== design/convolution_3x3_mirror_border.sv =====
// 3x3 RGB convolution with mirrored top/left and repeated bottom/right border.
// A pixel's first result passes the line store, window, product, row-sum and
// output registers. One pixel per cycle unless results stall; a pixel with
// several results holds input; the single filter datapath emits one per cycle.
// Reset clears positions, window, pipeline valids and loads register defaults;
// the line store memory is not cleared. Depends on cnv3_pkg and cnv3_if.
module convolution_3x3_mirror_border #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	cnv3_cfg_if.sink   cfg,
	cnv3_pix_if.sink   pixels,
	cnv3_res_if.source results
);
	import cnv3_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int W_LAST_RST = (MAX_WIDTH < FRAME_WIDTH_RST ? MAX_WIDTH : FRAME_WIDTH_RST) - 1;
	localparam int H_LAST_RST = (MAX_HEIGHT < FRAME_HEIGHT_RST ? MAX_HEIGHT : FRAME_HEIGHT_RST) - 1;

	logic [CFG_DATA_W-1:0] kern_top_q, kern_mid_q, kern_bot_q;
	logic [CW-1:0]         wlast_q, w_new;
	logic [RW-1:0]         hlast_q, h_new;
	logic [10:0]           w_req;
	logic [12:0]           h_req;
	kernel_t               kernel;
	logic                  accept, take, s1_valid, en, issue_valid, out_valid;
	item_t                 s1_item;
	rgb_t                  top_px, mid_px;
	issue_t                issue;
	result_t               result;

	always_comb begin
		w_req = cfg.data[10:0];
		h_req = cfg.data[12:0];
		if (w_req < 11'd2) begin
			w_new = CW'(1);
		end else if (32'(w_req) > MAX_WIDTH) begin
			w_new = CW'(MAX_WIDTH - 1);
		end else begin
			w_new = CW'(w_req - 11'd1);
		end
		if (h_req < 13'd2) begin
			h_new = RW'(1);
		end else if (32'(h_req) > MAX_HEIGHT) begin
			h_new = RW'(MAX_HEIGHT - 1);
		end else begin
			h_new = RW'(h_req - 13'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_top_q <= KERN_TOP_RST;
			kern_mid_q <= KERN_MID_RST;
			kern_bot_q <= KERN_BOT_RST;
			wlast_q <= CW'(W_LAST_RST);
			hlast_q <= RW'(H_LAST_RST);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_KERNEL_TOP: kern_top_q <= cfg.data;
				REG_KERNEL_MID: kern_mid_q <= cfg.data;
				REG_KERNEL_BOTTOM: kern_bot_q <= cfg.data;
				REG_FRAME_WIDTH: wlast_q <= w_new;
				REG_FRAME_HEIGHT: hlast_q <= h_new;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			kernel[0][j] = kern_top_q[COEF_W*j +: COEF_W];
			kernel[1][j] = kern_mid_q[COEF_W*j +: COEF_W];
			kernel[2][j] = kern_bot_q[COEF_W*j +: COEF_W];
		end
	end

	assign cfg.ready = 1'b1;
	assign pixels.ready = !s1_valid || take;
	assign accept = pixels.valid && pixels.ready;

	cnv3_line_store #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_line_store (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.pix({pixels.in_blue, pixels.in_green, pixels.in_red}),
		.wlast(wlast_q),
		.hlast(hlast_q),
		.advance(take),
		.s1_valid(s1_valid),
		.s1_item(s1_item),
		.top_px(top_px),
		.mid_px(mid_px)
	);

	cnv3_window_seq u_window_seq (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.s1_valid(s1_valid),
		.s1_item(s1_item),
		.top_px(top_px),
		.mid_px(mid_px),
		.take(take),
		.issue_valid(issue_valid),
		.issue(issue)
	);

	cnv3_filter u_filter (
		.clk(clk),
		.arst_n(arst_n),
		.out_ready(results.ready),
		.issue_valid(issue_valid),
		.issue(issue),
		.kernel(kernel),
		.en(en),
		.out_valid(out_valid),
		.result(result)
	);

	assign results.valid = out_valid;
	assign results.out_red = result.red;
	assign results.out_green = result.green;
	assign results.out_blue = result.blue;
	assign results.out_row = result.pos.row;
	assign results.out_col = result.pos.col;
	assign results.last_in_run = result.pos.last;

	a_stall_holds_window: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.ready) |-> !take)
		else $error("window advanced while the result register was stalled");

	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !take) |=> (s1_valid && $stable(s1_item)))
		else $error("line store stage item lost or changed while waiting");

	a_issue_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(issue_valid && !en) |=> (issue_valid && $stable(issue)))
		else $error("pending filter issue dropped during stall");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid)
		else $error("transferred pixel did not reach the line store stage");

endmodule
